// ----- rtl/sird_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sird_pkg
// Shared constants, types and the divider step for the radix text converter.
// ----------------------------------------------------------------------------
package sird_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 5;
    localparam int ALPHA_W  = 64;
    localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W    = $clog2(MAX_DIGITS);

    // quotient bits resolved per divider cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = VALUE_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int APB_DW = 64;
    localparam int APB_AW = 5;

    localparam logic [1:0] REG_DIGIT_COUNT   = 2'd0;
    localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RST_DIGIT_COUNT   = RADIX_W'(10);
    localparam logic [ALPHA_W-1:0] RST_ALPHABET_LOW  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] RST_ALPHABET_HIGH = 64'h6665646362613938;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_symbol;

    typedef struct packed {
        t_digit              rem;
        logic [DIV_BITS-1:0] quot;
    } t_div_res;

    // restoring division of one dividend slice by a small radix
    function automatic t_div_res div_step(input t_digit rem_in,
                                          input logic [DIV_BITS-1:0] slice,
                                          input logic [RADIX_W-1:0] radix);
        t_div_res            res;
        logic [RADIX_W-1:0]  t;
        t_digit              r;
        r = rem_in;
        res.quot = '0;
        for (int k = DIV_BITS - 1; k >= 0; k--) begin
            t = {r, slice[k]};
            if (t >= radix) begin
                t = t - radix;
                res.quot[k] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        res.rem = r;
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/signed_int_to_radix_digits.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits
// Writes a signed 32-bit word out as text in a configurable radix.
// ----------------------------------------------------------------------------
// One input word yields its text one character per output word, most
// significant digit first, with a leading '-' for negatives and tlast on the
// final character. A shared divider resolves 8 quotient bits a cycle;
// characters then leave at one a cycle while the downstream side takes
// them. The next word is accepted only once the final character has been
// issued. If the alphabet is unusable the word is dropped with no text.
// Registers: digit_count at 0x00, alphabet_low at 0x08, alphabet_high at 0x10.
module signed_int_to_radix_digits (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic signed [sird_pkg::VALUE_W-1:0] s_axis_tdata, // [31:0] value
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [sird_pkg::CHAR_W-1:0]       m_axis_tdata,  // [7:0] character
    output logic                              m_axis_tlast,  // last
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sird_pkg::APB_AW-1:0]  paddr,
    input  wire logic [sird_pkg::APB_DW-1:0]  pwdata,
    output logic [sird_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import sird_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [RADIX_W-1:0] r_digit_count;
    logic [ALPHA_W-1:0] r_alpha_low, r_alpha_high;
    logic               r_alpha_ok, n_alpha_ok;

    logic [1:0]         r_state, n_state;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_neg, n_neg;
    t_digit             r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_digit             r_store [MAX_DIGITS];

    logic               r_m_valid, n_m_valid;
    t_symbol            r_m_data, n_m_data;
    logic               r_m_last, n_m_last;

    t_symbol            sym [MAX_RADIX];
    t_div_res           div_res;
    logic               out_free;
    logic               cfg_wr;
    logic               store_wr;

    // ---- configuration ----
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= RST_DIGIT_COUNT;
            r_alpha_low   <= RST_ALPHABET_LOW;
            r_alpha_high  <= RST_ALPHABET_HIGH;
            r_alpha_ok    <= 1'b0;
        end else begin
            r_alpha_ok <= n_alpha_ok;
            if (cfg_wr) begin
                unique case (paddr[APB_AW-1:3])
                    REG_DIGIT_COUNT:   r_digit_count <= pwdata[RADIX_W-1:0];
                    REG_ALPHABET_LOW:  r_alpha_low   <= pwdata;
                    REG_ALPHABET_HIGH: r_alpha_high  <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[APB_AW-1:3])
            REG_DIGIT_COUNT:   prdata = {{(APB_DW-RADIX_W){1'b0}}, r_digit_count};
            REG_ALPHABET_LOW:  prdata = r_alpha_low;
            REG_ALPHABET_HIGH: prdata = r_alpha_high;
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < MAX_RADIX; k++) begin
            if (k < 8) sym[k] = r_alpha_low[8*k +: 8];
            else       sym[k] = r_alpha_high[8*(k-8) +: 8];
        end
    end

    // alphabet check, registered; read in the cycle after a word is taken
    always_comb begin
        n_alpha_ok = (r_digit_count >= RADIX_W'(2)) &&
                     (r_digit_count <= RADIX_W'(MAX_RADIX));
        for (int a = 0; a < MAX_RADIX; a++) begin
            if (RADIX_W'(a) < r_digit_count) begin
                if (sym[a] == '0 || sym[a] == CH_PLUS || sym[a] == CH_MINUS)
                    n_alpha_ok = 1'b0;
                for (int b = a + 1; b < MAX_RADIX; b++) begin
                    if (RADIX_W'(b) < r_digit_count && sym[a] == sym[b])
                        n_alpha_ok = 1'b0;
                end
            end
        end
    end

    // ---- sequencer ----
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;
    assign div_res       = div_step(r_rem, r_mag[VALUE_W-1 -: DIV_BITS], r_digit_count);

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_rem     = r_rem;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_m_valid = r_m_valid & ~m_axis_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        store_wr  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_neg   = s_axis_tdata[VALUE_W-1];
                    n_mag   = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + VALUE_W'(1))
                                                      : s_axis_tdata;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0 && r_step == '0 && !r_alpha_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_mag  = {r_mag[VALUE_W-DIV_BITS-1:0], div_res.quot};
                    n_rem  = div_res.rem;
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        store_wr = 1'b1;
                        n_rem    = '0;
                        n_cnt    = r_cnt + CNT_W'(1);
                        n_idx    = r_cnt[IDX_W-1:0];
                        if (n_mag == '0 || n_cnt == CNT_W'(MAX_DIGITS))
                            n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = CH_MINUS;
                    n_m_last  = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = sym[r_store[r_idx]];
                    n_m_last  = (r_idx == '0);
                    n_idx     = r_idx - IDX_W'(1);
                    if (r_idx == '0)
                        n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        if (store_wr)
            r_store[r_cnt[IDX_W-1:0]] <= div_res.rem;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // ---- checks ----
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while converter busy");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_alpha_ok) |-> ({1'b0, r_rem} < r_digit_count))
        else $error("divider remainder not below radix");

    a_last_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_idx == '0) |=>
        (m_axis_tvalid && m_axis_tlast && r_state == S_IDLE))
        else $error("final character not marked or sequencer not idle");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN && out_free) |=> (!m_axis_tlast && r_state == S_EMIT))
        else $error("sign character marked last");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// A directed table (reset values, extremes, rejected alphabets) runs first.
// Random phases follow over many radices and alphabets, with sender gaps,
// receiver stalls and one long receiver hold-off. Every character word is
// compared with a predicted text.
// ----------------------------------------------------------------------------
module testbench;
    import sird_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int WD_LIMIT     = 4000;
    localparam int PRINT_CAP    = 100;

    typedef enum { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle_mode;
    typedef enum { ROW_WORD, ROW_REG } t_row_kind;
    typedef enum { FLAW_LOW_RADIX, FLAW_HIGH_RADIX, FLAW_ZERO, FLAW_PLUS, FLAW_MINUS,
                   FLAW_DUP } t_flaw;

    typedef struct packed {
        t_symbol ch;
        logic    last;
    } t_char_exp;

    typedef struct {
        bit    typed;
        string text;
    } t_pending_word;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  regsel;
        logic [63:0] data;
        logic [31:0] value;
        bit          typed;
        string       text;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;   // [31:0] value
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]  m_axis_tdata;        // [7:0] character
    logic               m_axis_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // local copy of the register file
    logic [RADIX_W-1:0] cfg_radix;
    logic [63:0]        cfg_alpha_lo;
    logic [63:0]        cfg_alpha_hi;

    t_char_exp      expected_chars[$];
    t_pending_word  word_q[$];
    t_stim_row      directed_rows[$];

    t_idle_mode idle_mode = IDLE_NONE;
    bit         hold_req = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left = 0;
    int         wd_count = 0;
    int         errors = 0;
    int         n_words = 0;
    int         n_rejected = 0;
    int         n_chars = 0;
    int         n_reg_writes = 0;

    signed_int_to_radix_digits uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int sender_gap_pct();
        case (idle_mode)
            IDLE_SEND: return 77;
            IDLE_BOTH: return 12;
            default:   return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 77;
            IDLE_BOTH: return 12;
            default:   return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < PRINT_CAP)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- text predictor ----------------

    function automatic t_symbol symbol_for(input int d);
        if (d < 8)
            return cfg_alpha_lo[8*d +: 8];
        return cfg_alpha_hi[8*(d-8) +: 8];
    endfunction

    function automatic bit alphabet_usable();
        t_symbol s;
        if (cfg_radix < 2 || cfg_radix > MAX_RADIX)
            return 1'b0;
        for (int a = 0; a < cfg_radix; a++) begin
            s = symbol_for(a);
            if (s == 8'h00 || s == CH_PLUS || s == CH_MINUS)
                return 1'b0;
            for (int b = a + 1; b < cfg_radix; b++)
                if (symbol_for(b) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [31:0] rad;
        t_digit      digs[MAX_DIGITS];
        int          cnt;
        t_char_exp   e;
        if (!alphabet_usable())
            return;
        rad = 32'(cfg_radix);
        mag = raw[31] ? (~raw + 32'd1) : raw;
        cnt = 0;
        do begin
            digs[cnt] = t_digit'(mag % rad);
            mag = mag / rad;
            cnt++;
        end while (mag != 0 && cnt < MAX_DIGITS);
        if (raw[31]) begin
            e.ch = CH_MINUS;
            e.last = 1'b0;
            expected_chars.push_back(e);
        end
        for (int i = cnt; i > 0; i--) begin
            e.ch = symbol_for(int'(digs[i-1]));
            e.last = (i == 1);
            expected_chars.push_back(e);
        end
    endfunction

    function automatic void push_typed_text(input string s);
        t_char_exp e;
        for (int i = 0; i < s.len(); i++) begin
            e.ch = t_symbol'(s[i]);
            e.last = (i == s.len() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        t_char_exp     want;
        t_pending_word pw;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_chars++;
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character",
                                    64'({m_axis_tlast, m_axis_tdata}), 64'd0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata != want.ch)
                        report_mismatch("character", 64'(m_axis_tdata), 64'(want.ch));
                    if (m_axis_tlast != want.last)
                        report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_words++;
                if (!alphabet_usable())
                    n_rejected++;
                pw = word_q.pop_front();
                if (pw.typed)
                    push_typed_text(pw.text);
                else
                    predict_text(s_axis_tdata);
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // watchdog on cycles without any accepted word, delivered character or register access
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable) || !i_rst_n)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("timeout after %0d idle cycles", wd_count);
            $display("signed_int_to_radix_digits test failed");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic apb_xfer(input bit wr, input logic [1:0] regsel, input logic [63:0] wdata,
                            output logic [63:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {regsel, 3'b000};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] regsel);
        logic [63:0] rd;
        logic [63:0] want;
        logic [63:0] mask;
        apb_xfer(1'b0, regsel, 64'd0, rd);
        case (regsel)
            REG_DIGIT_COUNT: begin
                want = {59'd0, cfg_radix};
                mask = 64'h1F;
            end
            REG_ALPHABET_LOW: begin
                want = cfg_alpha_lo;
                mask = '1;
            end
            default: begin
                want = cfg_alpha_hi;
                mask = '1;
            end
        endcase
        if ((rd & mask) != want)
            report_mismatch("register readback", rd & mask, want);
    endtask

    task automatic write_reg(input logic [1:0] regsel, input logic [63:0] data);
        logic [63:0] unused_rd;
        apb_xfer(1'b1, regsel, data, unused_rd);
        case (regsel)
            REG_DIGIT_COUNT:  cfg_radix = data[RADIX_W-1:0];
            REG_ALPHABET_LOW: cfg_alpha_lo = data;
            default:          cfg_alpha_hi = data;
        endcase
        n_reg_writes++;
        check_reg(regsel);
    endtask

    task automatic send_word(input logic [31:0] v, input bit typed, input string text);
        t_pending_word pw;
        pw.typed = typed;
        pw.text = text;
        word_q.push_back(pw);
        while ($urandom_range(0, 99) < sender_gap_pct()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // wait until all text is out, then let the block finish any dropped word
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0 || word_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [RADIX_W-1:0] radix, input logic [127:0] alpha);
        logic [63:0] cnt_word;
        settle();
        cnt_word = {$urandom, $urandom};
        cnt_word[RADIX_W-1:0] = radix;
        write_reg(REG_DIGIT_COUNT, cnt_word);
        write_reg(REG_ALPHABET_LOW, alpha[63:0]);
        write_reg(REG_ALPHABET_HIGH, alpha[127:64]);
    endtask

    // n distinct usable symbols, unused slots anything
    task automatic make_alphabet(input int n, output logic [127:0] alpha);
        t_symbol s;
        bit      clash;
        alpha = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < n) begin
                do begin
                    s = t_symbol'($urandom_range(1, 255));
                    clash = (s == CH_PLUS) || (s == CH_MINUS);
                    for (int j = 0; j < i; j++)
                        if (alpha[8*j +: 8] == s)
                            clash = 1'b1;
                end while (clash);
            end else begin
                s = t_symbol'($urandom_range(0, 255));
            end
            alpha[8*i +: 8] = s;
        end
    endtask

    task automatic apply_broken(input t_flaw flaw);
        logic [127:0] alpha;
        int           n;
        int           p;
        int           q;
        n = $urandom_range(2, 16);
        make_alphabet(n, alpha);
        p = $urandom_range(0, n - 1);
        case (flaw)
            FLAW_LOW_RADIX:  n = $urandom_range(0, 1);
            FLAW_HIGH_RADIX: n = $urandom_range(17, 31);
            FLAW_ZERO:       alpha[8*p +: 8] = 8'h00;
            FLAW_PLUS:       alpha[8*p +: 8] = CH_PLUS;
            FLAW_MINUS:      alpha[8*p +: 8] = CH_MINUS;
            default: begin
                q = (p + $urandom_range(1, n - 1)) % n;
                alpha[8*p +: 8] = alpha[8*q +: 8];
            end
        endcase
        apply_setting(RADIX_W'(n), alpha);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 40));
            1:       return 32'd0 - 32'($urandom_range(0, 40));
            2:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            3:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
            4:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_words(input int count, input t_idle_mode mode);
        idle_mode = mode;
        repeat (count) send_word(pick_value(), 1'b0, "");
    endtask

    function automatic void add_word(input logic [31:0] v, input bit typed, input string text);
        t_stim_row r;
        r.kind = ROW_WORD;
        r.regsel = REG_DIGIT_COUNT;
        r.data = '0;
        r.value = v;
        r.typed = typed;
        r.text = text;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [1:0] regsel, input logic [63:0] data);
        t_stim_row r;
        r.kind = ROW_REG;
        r.regsel = regsel;
        r.data = data;
        r.value = '0;
        r.typed = 1'b0;
        r.text = "";
        directed_rows.push_back(r);
    endfunction

    // ---------------- sequence ----------------

    initial begin
        logic [127:0] alpha;
        cfg_radix = RST_DIGIT_COUNT;
        cfg_alpha_lo = RST_ALPHABET_LOW;
        cfg_alpha_hi = RST_ALPHABET_HIGH;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_reg(REG_DIGIT_COUNT);
        check_reg(REG_ALPHABET_LOW);
        check_reg(REG_ALPHABET_HIGH);

        // decimal at reset
        add_word(32'd0, 1'b1, "0");
        add_word(32'd1, 1'b1, "1");
        add_word(32'hFFFF_FFFF, 1'b1, "-1");
        add_word(32'd10, 1'b1, "10");
        add_word(32'd0 - 32'd10, 1'b1, "-10");
        add_word(32'h7FFF_FFFF, 1'b1, "2147483647");
        add_word(32'h8000_0000, 1'b1, "-2147483648");
        add_word(32'd12345, 1'b0, "");
        add_word(32'd0 - 32'd987654, 1'b0, "");
        // hex
        add_reg(REG_DIGIT_COUNT, 64'd16);
        add_word(32'hFFFF_FFFF, 1'b1, "-1");
        add_word(32'd255, 1'b1, "ff");
        add_word(32'h7FFF_FFFF, 1'b1, "7fffffff");
        add_word(32'h8000_0000, 1'b1, "-80000000");
        // binary, longest text
        add_reg(REG_DIGIT_COUNT, 64'd2);
        add_word(32'h8000_0000, 1'b1, {"-1", "0000000", "00000000", "00000000", "00000000"});
        add_word(32'h7FFF_FFFF, 1'b0, "");
        add_word(32'd5, 1'b1, "101");
        // radix out of range
        add_reg(REG_DIGIT_COUNT, 64'd0);
        add_word(32'd42, 1'b1, "");
        add_reg(REG_DIGIT_COUNT, 64'd1);
        add_word(32'd42, 1'b1, "");
        add_reg(REG_DIGIT_COUNT, 64'd17);
        add_word(32'd0 - 32'd42, 1'b1, "");
        add_reg(REG_DIGIT_COUNT, 64'd31);
        add_word(32'd7, 1'b1, "");
        // bad symbols among the used ones
        add_reg(REG_DIGIT_COUNT, 64'd10);
        add_reg(REG_ALPHABET_LOW, 64'h3736_3534_2D32_3130);
        add_word(32'd3, 1'b1, "");
        add_reg(REG_ALPHABET_LOW, 64'h3736_3534_332B_3130);
        add_word(32'd3, 1'b1, "");
        add_reg(REG_ALPHABET_LOW, 64'h3736_3534_3332_3100);
        add_word(32'd0, 1'b1, "");
        add_reg(REG_ALPHABET_LOW, 64'h3036_3534_3332_3130);
        add_word(32'd5, 1'b1, "");
        add_reg(REG_ALPHABET_LOW, RST_ALPHABET_LOW);
        add_reg(REG_ALPHABET_HIGH, 64'h6665_6463_6261_3038);
        add_word(32'd1, 1'b1, "");
        // '-' in an unused slot is harmless
        add_reg(REG_ALPHABET_HIGH, 64'h6665_6463_2D61_3938);
        add_word(32'd0 - 32'd1234567, 1'b1, "-1234567");
        add_reg(REG_ALPHABET_HIGH, RST_ALPHABET_HIGH);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(directed_rows[i].regsel, directed_rows[i].data);
            end else begin
                send_word(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].text);
            end
        end

        // decimal, no idling, with the long receiver hold-off
        apply_setting(RADIX_W'(10), {RST_ALPHABET_HIGH, RST_ALPHABET_LOW});
        hold_req <= 1'b1;
        run_words(60, IDLE_NONE);
        apply_setting(RADIX_W'(2), {RST_ALPHABET_HIGH, RST_ALPHABET_LOW});
        run_words(40, IDLE_SEND);
        apply_setting(RADIX_W'(16), {RST_ALPHABET_HIGH, RST_ALPHABET_LOW});
        run_words(50, IDLE_RECV);

        for (int k = 0; k < 7; k++) begin
            int n;
            n = (k == 0) ? 16 : (k == 1) ? 2 : $urandom_range(2, 16);
            make_alphabet(n, alpha);
            apply_setting(RADIX_W'(n), alpha);
            run_words(25, t_idle_mode'(k % 4));
        end

        for (int f = FLAW_LOW_RADIX; f <= FLAW_DUP; f++) begin
            apply_broken(t_flaw'(f));
            run_words(3, t_idle_mode'(f % 4));
        end

        apply_setting(RADIX_W'(10), {RST_ALPHABET_HIGH, RST_ALPHABET_LOW});
        run_words(20, IDLE_BOTH);

        settle();
        if (expected_chars.size() != 0)
            report_mismatch("characters never delivered", 64'(expected_chars.size()), 64'd0);

        $display("Covered %0d words (%0d against an unusable alphabet), %0d characters out,",
                 n_words, n_rejected, n_chars);
        $display("over %0d register writes: radix 0 to 31, fixed and random alphabets.",
                 n_reg_writes);
        if (errors == 0)
            $display("signed_int_to_radix_digits test passed");
        else
            $display("signed_int_to_radix_digits test failed");
        $finish;
    end

endmodule
